@@ rtl/ssg_pkg.sv @@
// ----------------------------------------------------------------------------
// ssg_pkg: shared types and constants of the stepper step generator
// Holds the action codes, the field widths and the structs that connect the
// sequencer with the shared serial divider.
// ----------------------------------------------------------------------------
package ssg_pkg;

   // motors driven in lockstep and the width of the direction field
   localparam int NumMotors  = 4;
   localparam int DirBits    = 4;

   // divider operand widths: a 33-bit dividend covers the exact position delta
   localparam int DivW       = 33;
   localparam int DivisorW   = 16;
   localparam int DivCntW    = 6;

   // field widths
   localparam int PosW       = 32;
   localparam int StepsW     = 24;
   localparam int RemW       = 25;
   localparam int IvW        = 20;
   localparam int SpeedW     = 16;
   localparam int ActionW    = 3;

   // action codes
   localparam logic [ActionW-1:0] ACT_TICK   = 3'd0;
   localparam logic [ActionW-1:0] ACT_MOVE   = 3'd1;
   localparam logic [ActionW-1:0] ACT_ROTATE = 3'd2;
   localparam logic [ActionW-1:0] ACT_STOP   = 3'd3;
   localparam logic [ActionW-1:0] ACT_HOME   = 3'd4;

   // configuration register indexes
   localparam logic [1:0] CSR_STEPS_PER_REV = 2'd0;
   localparam logic [1:0] CSR_CYCLES_PER_MS = 2'd1;
   localparam logic [1:0] CSR_INVERT_MASK   = 2'd2;

   // latched motion sign codes
   localparam logic [1:0] SIGN_ZERO = 2'b00;
   localparam logic [1:0] SIGN_POS  = 2'b01;
   localparam logic [1:0] SIGN_NEG  = 2'b11;

   // request to the divider
   typedef struct packed {
      logic                start;
      logic [DivW-1:0]     dividend;
      logic [DivisorW-1:0] divisor;
   } div_req_type;

   // divider result; done pulses for one cycle, values hold afterwards
   typedef struct packed {
      logic                done;
      logic [DivW-1:0]     quotient;
      logic [DivisorW-1:0] remainder;
   } div_rsp_type;

endpackage

@@ rtl/stepper_step_generator_unit.sv @@
// ----------------------------------------------------------------------------
// stepper_step_generator_unit: step pulse generator for a motor group
// Keeps the group position and the latched move, steps on tick items and
// latches moves through a shared serial divider.
// ----------------------------------------------------------------------------
// Usage:
//   req_* carries one item per transaction: req_tuser is the action, req_tdata
//   the command fields. rsp_* returns exactly one result per item.
//   csr_* writes steps_per_rev, cycles_per_ms and invert_mask; the user must write only while idle, unchecked.
// Sequence and throughput:
//   tick, stop, set home and unused actions: result registered in the cycle after
//   acceptance, one item per cycle while the receiver takes results.
//   rotate steps: one division (cycles_per_ms / speed).
//   move to step: two divisions on the same divider (delta modulo
//   steps_per_rev, then the step interval).
//   req_tready is low while a command is in the divider.
// Reset:
//   position, move state and direction levels clear; registers take their
//   defaults (200, 1000, 0). No result is pending.
// Stall:
//   while rsp_tready is low the result holds and req_tready stays low.
// ----------------------------------------------------------------------------
module stepper_step_generator_unit (
   input  logic        clock,
   input  logic        reset,
   // command channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [79:0] req_tdata,  // target_step[31:0], step_count[55:32],
                                   // rotate_ccw[56], speed[72:57], zero fill
   input  logic [2:0]  req_tuser,  // action[2:0]
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // position[31:0], moving[32], step_pulse[33],
                                   // direction_levels[37:34], home_refused[38]
   // configuration write port
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [19:0] csr_wdata
);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MOD  = 2'd1;
   localparam logic [1:0] ST_DIV  = 2'd2;

   // configuration registers
   logic [15:0]                   spr_ff;
   logic [ssg_pkg::IvW-1:0]       cpm_ff;
   logic [ssg_pkg::DirBits-1:0]   inv_ff;

   // motion state
   logic [1:0]                    state_ff, state_in;
   logic [ssg_pkg::PosW-1:0]      pos_ff, pos_in;
   logic [ssg_pkg::RemW-1:0]      remd_ff, remd_in;
   logic [1:0]                    sign_ff, sign_in;
   logic [ssg_pkg::IvW-1:0]       iv_ff, iv_in;
   logic [ssg_pkg::IvW-1:0]       css_ff, css_in;
   logic [ssg_pkg::DirBits-1:0]   dir_ff, dir_in;

   // command held across divisions
   logic                          neg_ff, neg_in;
   logic                          ccw_ff, ccw_in;
   logic [ssg_pkg::StepsW-1:0]    steps_ff, steps_in;
   logic [ssg_pkg::SpeedW-1:0]    speed_ff, speed_in;

   // output register
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [39:0]                   rsp_data_ff, rsp_data_in;

   ssg_pkg::div_req_type          div_req;
   ssg_pkg::div_rsp_type          div_rsp;

   // input fields
   logic [ssg_pkg::ActionW-1:0]   f_action;
   logic [ssg_pkg::PosW-1:0]      f_target;
   logic [ssg_pkg::StepsW-1:0]    f_steps;
   logic                          f_ccw;
   logic [ssg_pkg::SpeedW-1:0]    f_speed;

   logic                          req_fire;
   logic                          load_out;
   logic                          pulse;
   logic                          refused;
   logic signed [ssg_pkg::DivW-1:0] diff;
   logic [ssg_pkg::DivW-1:0]      diff_mag;
   logic [15:0]                   modulus;
   logic [ssg_pkg::IvW-1:0]       quo20;
   logic                          lv_ccw;
   logic [ssg_pkg::DirBits-1:0]   levels;
   logic [ssg_pkg::RemW-1:0]      steps_ext;

   assign f_action = req_tuser;
   assign f_target = req_tdata[31:0];
   assign f_steps  = req_tdata[55:32];
   assign f_ccw    = req_tdata[56];
   assign f_speed  = req_tdata[72:57];

   assign req_tready = (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign req_fire   = req_tvalid && req_tready;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   ssg_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   // exact signed delta to the target and its magnitude
   always_comb begin
      diff     = $signed({f_target[31], f_target}) - $signed({pos_ff[31], pos_ff});
      diff_mag = diff[ssg_pkg::DivW-1] ? ssg_pkg::DivW'(-diff) : ssg_pkg::DivW'(diff);
      modulus  = (spr_ff == 16'd0) ? 16'd1 : spr_ff;
   end

   // direction levels for the rotation being latched
   always_comb begin
      lv_ccw = ccw_ff;
      levels = '0;
      for (int i = 0; i < ssg_pkg::DirBits; i++) begin
         if (i < ssg_pkg::NumMotors) begin
            levels[i] = (~lv_ccw) ^ inv_ff[i];
         end
      end
      steps_ext = {1'b0, steps_ff};
      quo20     = div_rsp.quotient[ssg_pkg::IvW-1:0];
   end

   // sequencer and state update
   always_comb begin
      state_in     = state_ff;
      pos_in       = pos_ff;
      remd_in      = remd_ff;
      sign_in      = sign_ff;
      iv_in        = iv_ff;
      css_in       = css_ff;
      dir_in       = dir_ff;
      neg_in       = neg_ff;
      ccw_in       = ccw_ff;
      steps_in     = steps_ff;
      speed_in     = speed_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;
      load_out     = 1'b0;
      pulse        = 1'b0;
      refused      = 1'b0;
      div_req      = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (f_action)
                  ssg_pkg::ACT_TICK: begin
                     load_out = 1'b1;
                     if (remd_ff == '0) begin
                        sign_in = ssg_pkg::SIGN_ZERO;
                     end else if (remd_ff[ssg_pkg::RemW-1]) begin
                        sign_in = ssg_pkg::SIGN_NEG;
                     end else begin
                        sign_in = ssg_pkg::SIGN_POS;
                     end
                     if (sign_in != ssg_pkg::SIGN_ZERO) begin
                        if (css_ff >= iv_ff) begin
                           pulse  = 1'b1;
                           css_in = '0;
                           if (sign_in == ssg_pkg::SIGN_POS) begin
                              pos_in  = pos_ff + 32'd1;
                              remd_in = remd_ff - 25'd1;
                           end else begin
                              pos_in  = pos_ff - 32'd1;
                              remd_in = remd_ff + 25'd1;
                           end
                        end else begin
                           css_in = css_ff + 20'd1;
                        end
                     end
                  end
                  ssg_pkg::ACT_MOVE: begin
                     div_req.start    = 1'b1;
                     div_req.dividend = diff_mag;
                     div_req.divisor  = modulus;
                     neg_in           = diff[ssg_pkg::DivW-1];
                     speed_in         = f_speed;
                     state_in         = ST_MOD;
                  end
                  ssg_pkg::ACT_ROTATE: begin
                     div_req.start    = 1'b1;
                     div_req.dividend = {13'd0, cpm_ff};
                     div_req.divisor  = (f_speed == 16'd0) ? 16'd1 : f_speed;
                     ccw_in           = f_ccw;
                     steps_in         = f_steps;
                     state_in         = ST_DIV;
                  end
                  ssg_pkg::ACT_STOP: begin
                     load_out = 1'b1;
                     remd_in  = '0;
                  end
                  ssg_pkg::ACT_HOME: begin
                     load_out = 1'b1;
                     if (sign_ff != ssg_pkg::SIGN_ZERO) begin
                        refused = 1'b1;
                     end else begin
                        pos_in = '0;
                     end
                  end
                  default: begin
                     load_out = 1'b1;
                  end
               endcase
            end
         end
         ST_MOD: begin
            // delta remainder ready: take its sign, then divide for the interval
            if (div_rsp.done) begin
               ccw_in           = !(neg_ff && (div_rsp.remainder != '0));
               steps_in         = {8'd0, div_rsp.remainder};
               div_req.start    = 1'b1;
               div_req.dividend = {13'd0, cpm_ff};
               div_req.divisor  = (speed_ff == 16'd0) ? 16'd1 : speed_ff;
               state_in         = ST_DIV;
            end
         end
         ST_DIV: begin
            // interval ready: latch the rotation
            if (div_rsp.done) begin
               iv_in    = (quo20 == '0) ? 20'd1 : quo20;
               css_in   = iv_in;
               remd_in  = ccw_ff ? steps_ext : ssg_pkg::RemW'(-steps_ext);
               dir_in   = levels;
               load_out = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // result transaction
      if (load_out) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {1'b0, refused, dir_in, pulse,
                         (sign_in != ssg_pkg::SIGN_ZERO), pos_in};
      end
   end

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         spr_ff <= 16'd200;
         cpm_ff <= 20'd1000;
         inv_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            ssg_pkg::CSR_STEPS_PER_REV: spr_ff <= csr_wdata[15:0];
            ssg_pkg::CSR_CYCLES_PER_MS: cpm_ff <= csr_wdata;
            ssg_pkg::CSR_INVERT_MASK:   inv_ff <= csr_wdata[3:0];
            default: begin
            end
         endcase
      end
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         pos_ff       <= '0;
         remd_ff      <= '0;
         sign_ff      <= ssg_pkg::SIGN_ZERO;
         iv_ff        <= '0;
         css_ff       <= '0;
         dir_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         pos_ff       <= pos_in;
         remd_ff      <= remd_in;
         sign_ff      <= sign_in;
         iv_ff        <= iv_in;
         css_ff       <= css_in;
         dir_ff       <= dir_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      neg_ff      <= neg_in;
      ccw_ff      <= ccw_in;
      steps_ff    <= steps_in;
      speed_ff    <= speed_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

@@ rtl/ssg_divider.sv @@
// ----------------------------------------------------------------------------
// ssg_divider: serial restoring divider
// Produces one quotient bit per cycle. The divisor must be nonzero.
// ----------------------------------------------------------------------------
module ssg_divider (
   input  logic                 clock,
   input  logic                 reset,
   input  ssg_pkg::div_req_type div_req,
   output ssg_pkg::div_rsp_type div_rsp
);

   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [ssg_pkg::DivCntW-1:0]  cnt_ff, cnt_in;
   logic [ssg_pkg::DivW-1:0]     quo_ff, quo_in;
   logic [ssg_pkg::DivisorW-1:0] rem_ff, rem_in;
   logic [ssg_pkg::DivisorW-1:0] dsr_ff, dsr_in;
   logic [ssg_pkg::DivisorW:0]   shifted;
   logic                         fits;

   // one restoring step: bring down the next dividend bit, trial subtract
   always_comb begin
      shifted = {rem_ff, quo_ff[ssg_pkg::DivW-1]};
      fits    = (shifted >= {1'b0, dsr_ff});
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (div_req.start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = div_req.dividend;
         rem_in  = '0;
         dsr_in  = div_req.divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[ssg_pkg::DivW-2:0], fits};
         if (fits) begin
            rem_in = ssg_pkg::DivisorW'(shifted - {1'b0, dsr_ff});
         end else begin
            rem_in = shifted[ssg_pkg::DivisorW-1:0];
         end
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff == ssg_pkg::DivCntW'(ssg_pkg::DivW - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

endmodule
